>>> rtl/core/prd_pkg.sv
// Shared types and constants for the package record deframer.
// Holds the result word layout, status codes, register indexes and the signature table.
// No dependencies.
`timescale 1ns / 1ps

package prd_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_INDEX = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMIT_ALL     = 1'd1;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADSIG   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  localparam logic [2:0] SIG_LAST = 3'd6;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] record_number;
    logic [31:0] record_length;
    logic        last_of_record;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } res_pair_t;

  function automatic logic [7:0] sig_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0: c = 8'h51;
      3'd1: c = 8'h20;
      3'd2: c = 8'h50;
      3'd3: c = 8'h41;
      3'd4: c = 8'h43;
      3'd5: c = 8'h4B;
      3'd6: c = 8'h20;
      3'd7: c = 8'h51;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/prd_in_stage.sv
// Input register stage of the package record deframer.
// Holds one accepted stream word until the core consumes it; uses prd_pkg.
`timescale 1ns / 1ps

module prd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_package,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_eop
);
  import prd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       eop_r;
  logic       load;

  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_eop   = eop_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_data_byte;
      eop_r  <= in_end_of_package;
    end
  end

endmodule

>>> rtl/core/prd_core.sv
// Framing state and per-word decode of the package record deframer.
// Tracks signature, header fields, name and payload and forms up to two results per word.
// Uses prd_pkg.
`timescale 1ns / 1ps

module prd_core #(
  parameter int RECORD_INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  eop,
  input  logic [15:0]           wanted_index,
  input  logic                  emit_all,
  output prd_pkg::res_pair_t    results
);
  import prd_pkg::*;

  localparam int CMP_W = (RECORD_INDEX_BITS > 16) ? RECORD_INDEX_BITS : 16;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_NLEN = 3'd2;
  localparam logic [2:0] PH_NAME = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  logic [2:0]                   phase_r, phase_nxt;
  logic [2:0]                   sig_pos_r, sig_pos_nxt;
  logic [31:0]                  fc_r, fc_nxt;
  logic [31:0]                  ps_r, ps_nxt;
  logic [31:0]                  nl_r, nl_nxt;
  logic [RECORD_INDEX_BITS-1:0] rec_r, rec_nxt;
  logic                         found_r, found_nxt;

  logic [31:0]      fc_inc;
  logic [31:0]      byte_sh;
  logic [CMP_W-1:0] rec_ext;
  logic [CMP_W-1:0] rec_nxt_ext;
  logic [CMP_W-1:0] want_ext;
  logic             rec_eq;
  logic             sel;
  logic             enter_pl;
  logic             finish;
  logic             have_rec;
  logic             have_eop;
  res_t             rec_res;
  res_t             eop_res;

  assign fc_inc   = fc_r + 32'd1;
  assign byte_sh  = {24'd0, data_byte} << {fc_r[1:0], 3'b000};
  assign rec_ext  = CMP_W'(rec_r);
  assign want_ext = CMP_W'(wanted_index);
  assign rec_eq   = (rec_ext == want_ext);
  assign sel      = emit_all || (rec_eq && !found_r);

  always_comb begin
    phase_nxt   = phase_r;
    sig_pos_nxt = sig_pos_r;
    fc_nxt      = fc_r;
    ps_nxt      = ps_r;
    nl_nxt      = nl_r;
    rec_nxt     = rec_r;
    found_nxt   = found_r;
    enter_pl    = 1'b0;
    finish      = 1'b0;
    have_rec    = 1'b0;
    rec_res     = '0;
    have_eop    = 1'b0;
    eop_res     = '0;
    rec_nxt_ext = '0;

    unique case (phase_r)
      PH_SIG: begin
        if (data_byte != sig_char(sig_pos_r)) begin
          have_rec       = 1'b1;
          rec_res.status = ST_BADSIG;
          phase_nxt      = PH_SKIP;
        end else if (sig_pos_r >= SIG_LAST) begin
          phase_nxt = PH_SIZE;
          fc_nxt    = 32'd0;
        end else begin
          sig_pos_nxt = sig_pos_r + 3'd1;
        end
      end
      PH_SIZE: begin
        ps_nxt = (fc_r == 32'd0) ? {24'd0, data_byte} : (ps_r | byte_sh);
        fc_nxt = fc_inc;
        if (fc_inc >= 32'd4) begin
          phase_nxt = PH_NLEN;
          fc_nxt    = 32'd0;
        end
      end
      PH_NLEN: begin
        nl_nxt = (fc_r == 32'd0) ? {24'd0, data_byte} : (nl_r | byte_sh);
        fc_nxt = fc_inc;
        if (fc_inc >= 32'd4) begin
          fc_nxt = 32'd0;
          if (nl_nxt == 32'd0) begin
            enter_pl = 1'b1;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        fc_nxt = fc_inc;
        if (fc_inc >= nl_r) begin
          enter_pl = 1'b1;
        end
      end
      PH_DATA: begin
        if (sel) begin
          have_rec               = 1'b1;
          rec_res.payload_byte   = ~data_byte;
          rec_res.record_number  = rec_ext[15:0];
          rec_res.record_length  = ps_r;
          rec_res.last_of_record = (fc_inc >= ps_r);
          rec_res.status         = ST_DATA;
        end
        fc_nxt = fc_inc;
        if (fc_inc >= ps_r) begin
          finish = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (enter_pl) begin
      fc_nxt = 32'd0;
      if (ps_r == 32'd0) begin
        if (sel) begin
          have_rec              = 1'b1;
          rec_res.record_number = rec_ext[15:0];
          rec_res.status        = ST_EMPTY;
        end
        finish = 1'b1;
      end else begin
        phase_nxt = PH_DATA;
      end
    end

    if (finish) begin
      found_nxt = found_r || rec_eq;
      rec_nxt   = rec_r + RECORD_INDEX_BITS'(1);
      phase_nxt = PH_SIZE;
      fc_nxt    = 32'd0;
    end

    rec_nxt_ext = CMP_W'(rec_nxt);

    if (eop) begin
      if (phase_nxt == PH_SIG) begin
        have_eop       = 1'b1;
        eop_res.status = ST_BADSIG;
      end else if (phase_nxt == PH_SIZE && fc_nxt == 32'd0) begin
        if (!emit_all && !found_nxt) begin
          have_eop              = 1'b1;
          eop_res.record_number = wanted_index;
          eop_res.status        = ST_NOTFOUND;
        end
      end else if (phase_nxt != PH_SKIP) begin
        have_eop              = 1'b1;
        eop_res.record_number = rec_nxt_ext[15:0];
        eop_res.record_length = ps_nxt;
        eop_res.status        = ST_TRUNC;
      end
      phase_nxt   = PH_SIG;
      sig_pos_nxt = 3'd0;
      fc_nxt      = 32'd0;
      ps_nxt      = 32'd0;
      nl_nxt      = 32'd0;
      rec_nxt     = '0;
      found_nxt   = 1'b0;
    end
  end

  assign results.v0 = have_rec || have_eop;
  assign results.r0 = have_rec ? rec_res : eop_res;
  assign results.v1 = have_rec && have_eop;
  assign results.r1 = eop_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      sig_pos_r <= 3'd0;
      fc_r      <= 32'd0;
      ps_r      <= 32'd0;
      nl_r      <= 32'd0;
      rec_r     <= '0;
      found_r   <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sig_pos_r <= sig_pos_nxt;
      fc_r      <= fc_nxt;
      ps_r      <= ps_nxt;
      nl_r      <= nl_nxt;
      rec_r     <= rec_nxt;
      found_r   <= found_nxt;
    end
  end

endmodule

>>> rtl/core/prd_out_pair.sv
// Result register of the package record deframer.
// Holds the one or two results of a word and hands them out one per handshake; uses prd_pkg.
`timescale 1ns / 1ps

module prd_out_pair (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  prd_pkg::res_pair_t pair_in,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output prd_pkg::res_t      out_res
);
  import prd_pkg::*;

  logic v0_r, v0_nxt;
  logic v1_r, v1_nxt;
  res_t r0_r;
  res_t r1_r;
  logic pop;

  assign out_valid = v0_r || v1_r;
  assign out_res   = v0_r ? r0_r : r1_r;
  assign pop       = out_valid && out_ready;
  assign free      = !out_valid || (pop && !(v0_r && v1_r));

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    if (load) begin
      v0_nxt = pair_in.v0;
      v1_nxt = pair_in.v1;
    end else if (pop) begin
      if (v0_r) begin
        v0_nxt = 1'b0;
      end else begin
        v1_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0_r <= pair_in.r0;
      r1_r <= pair_in.r1;
    end
  end

endmodule

>>> rtl/core/package_record_deframer_unit.sv
// The first result of a word is offered from the result register, which loads as the word
// leaves the input register, once the result register is free.
// Throughput: one word per cycle while the result register is free; a word that gives
// two results (only an end-of-package word can) holds that register for two output transfers.
// Reset (synchronous, rst_n low) returns the framer to the signature phase, clears
// wanted_index and emit_all, and empties the input and result registers.
`timescale 1ns / 1ps

module package_record_deframer_unit #(
  parameter int RECORD_INDEX_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_package,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_payload_byte,
  output logic [15:0]                      out_record_number,
  output logic [31:0]                      out_record_length,
  output logic                             out_last_of_record,
  output logic [2:0]                       out_status,
  input  logic                             cfg_we,
  input  logic [prd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prd_pkg::*;

  logic [15:0] wanted_index_r;
  logic        emit_all_r;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_eop;
  logic        pair_free;
  logic        advance;
  res_pair_t   pair;
  res_t        out_res;

  assign advance = s1_valid && pair_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_index_r <= 16'd0;
      emit_all_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WANTED_INDEX: wanted_index_r <= cfg_data;
        CFG_EMIT_ALL:     emit_all_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  prd_in_stage u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_package (in_end_of_package),
    .advance           (advance),
    .s1_valid          (s1_valid),
    .s1_byte           (s1_byte),
    .s1_eop            (s1_eop)
  );

  prd_core #(
    .RECORD_INDEX_BITS (RECORD_INDEX_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .data_byte    (s1_byte),
    .eop          (s1_eop),
    .wanted_index (wanted_index_r),
    .emit_all     (emit_all_r),
    .results      (pair)
  );

  prd_out_pair u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .pair_in   (pair),
    .free      (pair_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_payload_byte   = out_res.payload_byte;
  assign out_record_number  = out_res.record_number;
  assign out_record_length  = out_res.record_length;
  assign out_last_of_record = out_res.last_of_record;
  assign out_status         = out_res.status;

endmodule

>>> rtl/core/prd_checker.sv
// Port-level checks for the package record deframer and the bind that attaches them.
// Depends on prd_pkg and the package_record_deframer_unit ports.
`timescale 1ns / 1ps

module prd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_payload_byte,
  input logic [15:0] out_record_number,
  input logic [31:0] out_record_length,
  input logic        out_last_of_record,
  input logic [2:0]  out_status
);
  import prd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_payload_byte) && $stable(out_record_number)
      && $stable(out_record_length))
    else $error("Result word changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result offered right after reset.");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |-> out_payload_byte == 8'd0
      && !out_last_of_record)
    else $error("Status word carries payload data.");

  a_badsig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BADSIG |-> out_record_number == 16'd0
      && out_record_length == 32'd0)
    else $error("Bad signature word has record fields set.");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_record_length == 32'd0)
    else $error("Empty record word has a nonzero length.");

endmodule

bind package_record_deframer_unit prd_checker u_prd_checker (.*);
